// ===== hw/rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and the CRC byte update of the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_FLAG  = 8'h9E;
  localparam logic [7:0]  ESC_ESC   = 8'h9D;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  localparam int HDR_BYTES = 6;
  localparam int APB_AW    = 4;

  localparam logic [1:0] REG_REQUIRE = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_ESC   = 3'd2;
  localparam logic [2:0] ST_BAD_CRC   = 3'd3;
  localparam logic [2:0] ST_BAD_MODE  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;

  typedef struct packed {
    logic       tick;
    logic       is_flag;
    logic       is_esc;
    logic       esc_ok;
    logic [7:0] unesc;
    logic [7:0] raw;
  } item_t;

  typedef struct packed {
    logic        require_request;
    logic [7:0]  copy_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [2:0] status;
    logic [7:0] src_addr;
    logic [7:0] trg_addr;
    logic [7:0] frame_mode;
    logic [7:0] msg_id;
    logic [7:0] ans_id;
    logic [7:0] payload_length;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r ^ {8'h00, b};
  endfunction

endpackage

// ===== hw/rtl/sfr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_in_if
// Input channel: one line byte or one timer tick per transaction.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// ===== hw/rtl/sfr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_out_if
// Result channel: payload bytes and end-of-frame status records.
// ----------------------------------------------------------------------------
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [2:0] status;
  logic [7:0] src_addr;
  logic [7:0] trg_addr;
  logic [7:0] frame_mode;
  logic [7:0] msg_id;
  logic [7:0] ans_id;
  logic [7:0] payload_length;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output src_addr, output trg_addr, output frame_mode,
                  output msg_id, output ans_id, output payload_length,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input status, input src_addr, input trg_addr, input frame_mode,
                  input msg_id, input ans_id, input payload_length,
                  output ready);
endinterface

// ===== hw/rtl/stuffed_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_top
// Byte-stuffed frame receiver with header capture and CRC-16 check.
//
// The in_s channel carries one transaction per line byte or timer tick. The
// out_m channel returns payload bytes as they arrive and one end-of-frame
// record per frame, or a bad-start record for a stray byte in idle.
// Configuration registers sit on the APB port at byte addresses 0, 4 and 8:
// require_request, copy_limit and timeout_ticks.
// One transaction is taken every cycle while the result channel keeps up; a
// result is offered from the output register: each transaction waits first in
// the input queue, then the frame engine, whose CRC byte update is
// combinational, builds any result of it into the output register.
// If the result channel stalls, the output register holds its record and the
// two-entry input queue fills; in_s.ready drops only when the queue is full.
// Synchronous reset returns the engine to idle, empties the queue and the
// output register and loads the register defaults.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_top (
  input  logic                        clk,
  input  logic                        rst_n,
  sfr_in_if.sink                      in_s,
  sfr_out_if.source                   out_m,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sfr_pkg::*;

  cfg_t  cfg_r;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.require_request <= 1'b1;
      cfg_r.copy_limit      <= 8'd255;
      cfg_r.timeout_ticks   <= 16'd100;
    end else if (cfg_wr) begin
      unique case (paddr[APB_AW-1:2])
        REG_REQUIRE: cfg_r.require_request <= pwdata[0];
        REG_LIMIT:   cfg_r.copy_limit      <= pwdata[7:0];
        REG_TIMEOUT: cfg_r.timeout_ticks   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_AW-1:2])
      REG_REQUIRE: prdata = {31'd0, cfg_r.require_request};
      REG_LIMIT:   prdata = {24'd0, cfg_r.copy_limit};
      REG_TIMEOUT: prdata = {16'd0, cfg_r.timeout_ticks};
      default:     prdata = 32'd0;
    endcase
  end

  sfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_s),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .cfg     (cfg_r),
    .out_m   (out_m)
  );
endmodule

// ===== hw/rtl/sfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_front
// Accepts input transactions, classifies each byte and queues it for the
// frame engine in a two-entry queue.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic           clk,
  input  logic           rst_n,
  sfr_in_if.sink         in_s,
  output sfr_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);
  import sfr_pkg::*;

  item_t      ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.tick    = in_s.mode;
    cls.raw     = in_s.rx_byte;
    cls.is_flag = in_s.rx_byte == FLAG_BYTE;
    cls.is_esc  = in_s.rx_byte == ESC_BYTE;
    cls.esc_ok  = (in_s.rx_byte == ESC_FLAG) || (in_s.rx_byte == ESC_ESC);
    cls.unesc   = (in_s.rx_byte == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE;
  end

  assign in_s.ready = cnt_r != 2'd2;
  assign push       = in_s.valid && in_s.ready;
  assign q_valid    = cnt_r != 2'd0;
  assign q_item     = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef ASSERT_OFF
  ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("Queue count out of range.");
  ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("Queue popped while empty.");
  ap_pointers: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("Queue pointers disagree with the count.");
`endif
endmodule

// ===== hw/rtl/sfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_back
// Frame engine: unstuffing, header capture, CRC check, inter-byte timeout and
// the registered result stage.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sfr_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  input  sfr_pkg::cfg_t  cfg,
  sfr_out_if.source      out_m
);
  import sfr_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CRC  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crclo_r, crclo_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic [7:0]  hdr_nxt [HDR_BYTES];
  logic        out_valid_r;
  res_t        res_r, res_nxt;

  logic        have_res;
  logic        fin;
  logic [2:0]  fin_st;
  logic        emit;
  logic        bad_start;
  logic [7:0]  d;
  logic        go;
  logic [15:0] ticks_inc;
  logic [7:0]  cnt_inc;
  logic [7:0]  emit_sel;
  logic [7:0]  emit_cnt;
  logic [15:0] crc_got;

  assign q_pop     = q_valid && (!out_valid_r || out_m.ready);
  assign ticks_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign cnt_inc   = cnt_r + 8'd1;
  assign d         = esc_r ? q_item.unesc : q_item.raw;
  assign go        = esc_r ? q_item.esc_ok : !q_item.is_esc;
  assign crc_got   = {d, crclo_r};
  assign emit_sel  = (phase_r == PH_DATA) ? cnt_r : hdr_r[5];

  always_comb begin
    if (phase_r == PH_DATA || phase_r == PH_CRC) begin
      emit_cnt = (emit_sel < cfg.copy_limit) ? emit_sel : cfg.copy_limit;
    end else begin
      emit_cnt = 8'd0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    crclo_nxt = crclo_r;
    ticks_nxt = ticks_r;
    hdr_nxt   = hdr_r;
    fin       = 1'b0;
    fin_st    = ST_OK;
    emit      = 1'b0;
    bad_start = 1'b0;
    if (q_pop) begin
      if (q_item.tick) begin
        if (phase_r != PH_IDLE) begin
          ticks_nxt = ticks_inc;
          if (cfg.timeout_ticks != 16'd0 && ticks_inc >= cfg.timeout_ticks) begin
            fin    = 1'b1;
            fin_st = ST_TIMEOUT;
          end
        end
      end else begin
        ticks_nxt = 16'd0;
        if (phase_r == PH_IDLE) begin
          if (!q_item.is_flag) begin
            bad_start = 1'b1;
          end else begin
            phase_nxt = PH_HEAD;
            esc_nxt   = 1'b0;
            cnt_nxt   = 8'd0;
            crc_nxt   = 16'd0;
            crclo_nxt = 8'd0;
            for (int i = 0; i < HDR_BYTES; i++) begin
              hdr_nxt[i] = 8'd0;
            end
          end
        end else if (!go) begin
          if (esc_r) begin
            fin    = 1'b1;
            fin_st = ST_BAD_ESC;
          end else begin
            esc_nxt = 1'b1;
          end
        end else begin
          esc_nxt = 1'b0;
          unique case (phase_r)
            PH_HEAD: begin
              hdr_nxt[cnt_r[2:0]] = d;
              crc_nxt = crc_feed(crc_r, d);
              if (cnt_r == 8'd5) begin
                cnt_nxt   = 8'd0;
                phase_nxt = (d == 8'd0) ? PH_CRC : PH_DATA;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end
            PH_DATA: begin
              emit    = cnt_r < cfg.copy_limit;
              crc_nxt = crc_feed(crc_r, d);
              if (cnt_inc >= hdr_r[5]) begin
                cnt_nxt   = 8'd0;
                phase_nxt = PH_CRC;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end
            PH_CRC: begin
              if (cnt_r == 8'd0) begin
                crclo_nxt = d;
                cnt_nxt   = 8'd1;
              end else begin
                fin = 1'b1;
                if (crc_got != crc_r) begin
                  fin_st = ST_BAD_CRC;
                end else if (cfg.require_request && hdr_r[2] != 8'd0) begin
                  fin_st = ST_BAD_MODE;
                end else begin
                  fin_st = ST_OK;
                end
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
      if (fin) begin
        phase_nxt = PH_IDLE;
        esc_nxt   = 1'b0;
        cnt_nxt   = 8'd0;
        ticks_nxt = 16'd0;
      end
    end
  end

  // Result record built from the state before this transaction.
  always_comb begin
    have_res               = fin || emit || bad_start;
    res_nxt.kind           = !emit;
    res_nxt.data_byte      = emit ? d : 8'd0;
    res_nxt.byte_index     = emit ? cnt_r : 8'd0;
    res_nxt.status         = bad_start ? ST_BAD_START : (fin ? fin_st : ST_OK);
    res_nxt.src_addr       = bad_start ? 8'd0 : hdr_r[0];
    res_nxt.trg_addr       = bad_start ? 8'd0 : hdr_r[1];
    res_nxt.frame_mode     = bad_start ? 8'd0 : hdr_r[2];
    res_nxt.msg_id         = bad_start ? 8'd0 : hdr_r[3];
    res_nxt.ans_id         = bad_start ? 8'd0 : hdr_r[4];
    res_nxt.payload_length = fin ? emit_cnt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      esc_r       <= 1'b0;
      cnt_r       <= 8'd0;
      crc_r       <= 16'd0;
      crclo_r     <= 8'd0;
      ticks_r     <= 16'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= 8'd0;
      end
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      crclo_r <= crclo_nxt;
      ticks_r <= ticks_nxt;
      hdr_r   <= hdr_nxt;
      if (q_pop && have_res) begin
        out_valid_r <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && have_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_m.valid          = out_valid_r;
  assign out_m.kind           = res_r.kind;
  assign out_m.data_byte      = res_r.data_byte;
  assign out_m.byte_index     = res_r.byte_index;
  assign out_m.status         = res_r.status;
  assign out_m.src_addr       = res_r.src_addr;
  assign out_m.trg_addr       = res_r.trg_addr;
  assign out_m.frame_mode     = res_r.frame_mode;
  assign out_m.msg_id         = res_r.msg_id;
  assign out_m.ans_id         = res_r.ans_id;
  assign out_m.payload_length = res_r.payload_length;

`ifndef ASSERT_OFF
  ap_esc_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> phase_r != PH_IDLE) else $error("Escape pending outside a frame.");
  ap_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEAD |-> cnt_r < 8'd6) else $error("Header count out of range.");
  ap_crc_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CRC |-> cnt_r <= 8'd1) else $error("CRC byte count out of range.");
  ap_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> ticks_r == 16'd0) else $error("Tick count running in idle.");
`endif
endmodule

// ===== tb/stuffed_frame_receiver_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_top_tb
// Self-checking testbench for the byte-stuffed frame receiver.
//
// Line bytes and timer ticks are driven on the input channel: a few directed
// frames, then random frames with escapes, CRC faults, bad escapes, timeouts
// and stray bytes, over several register settings written on the APB port.
// A frame scoreboard predicts each payload byte and end-of-frame record and
// compares every result transaction field by field. Both channels idle and
// stall in random bursts, and the result side is held off once for long.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_top_tb;
  import sfr_pkg::*;

  localparam int ITEMS         = 900;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 50;

  typedef logic [7:0] octet_q_t[$];
  typedef enum int {FAULT_NONE, FAULT_CRC, FAULT_ESCAPE, FAULT_TIMEOUT} frame_fault_t;

  class frame_scoreboard;
    typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_PAYLOAD, RX_CHECKSUM} rx_state_t;

    bit          require_req;
    logic [7:0]  copy_max;
    logic [15:0] timeout_max;
    rx_state_t   rx_state;
    bit          esc_pending;
    logic [7:0]  count;
    logic [15:0] crc;
    logic [7:0]  hdr[6];
    logic [7:0]  crc_lo;
    logic [15:0] tick_count;
    res_t        expected_q[$];
    int          errors;

    function new();
      require_req = 1'b1;
      copy_max    = 8'd255;
      timeout_max = 16'd100;
      rx_state    = RX_IDLE;
      esc_pending = 1'b0;
      count       = '0;
      crc         = '0;
      foreach (hdr[i]) hdr[i] = '0;
      crc_lo      = '0;
      tick_count  = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_REQUIRE: require_req = value[0];
        REG_LIMIT:   copy_max = value[7:0];
        REG_TIMEOUT: timeout_max = value[15:0];
        default: ;
      endcase
    endfunction

    static function logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      logic        top;
      c = acc;
      for (int k = 0; k < 8; k++) begin
        top = c[15];
        c = c << 1;
        if (top) c = c ^ CRC_POLY;
      end
      return c ^ {8'h00, b};
    endfunction

    function logic [7:0] emitted();
      if (rx_state == RX_PAYLOAD) return (count < copy_max) ? count : copy_max;
      if (rx_state == RX_CHECKSUM) return (hdr[5] < copy_max) ? hdr[5] : copy_max;
      return 8'd0;
    endfunction

    function res_t header_record();
      res_t r;
      r = '0;
      r.src_addr   = hdr[0];
      r.trg_addr   = hdr[1];
      r.frame_mode = hdr[2];
      r.msg_id     = hdr[3];
      r.ans_id     = hdr[4];
      return r;
    endfunction

    function void close_frame(logic [2:0] st);
      res_t r;
      r = header_record();
      r.kind = 1'b1;
      r.status = st;
      r.payload_length = emitted();
      expected_q.push_back(r);
      rx_state    = RX_IDLE;
      esc_pending = 1'b0;
      count       = '0;
      tick_count  = '0;
    endfunction

    function void note_item(logic is_tick, logic [7:0] raw);
      logic [7:0]  b;
      logic [7:0]  idx;
      bit          emit;
      res_t        r;
      logic [15:0] got;
      b = raw;
      if (is_tick) begin
        if (rx_state == RX_IDLE) return;
        if (tick_count != 16'hFFFF) tick_count++;
        if (timeout_max != 0 && tick_count >= timeout_max) close_frame(ST_TIMEOUT);
        return;
      end
      tick_count = '0;
      if (rx_state == RX_IDLE) begin
        if (b != FLAG_BYTE) begin
          r = '0;
          r.kind = 1'b1;
          r.status = ST_BAD_START;
          expected_q.push_back(r);
        end else begin
          rx_state    = RX_HEADER;
          esc_pending = 1'b0;
          count       = '0;
          crc         = '0;
          crc_lo      = '0;
          foreach (hdr[i]) hdr[i] = '0;
        end
        return;
      end
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == ESC_FLAG) begin
          b = FLAG_BYTE;
        end else if (b == ESC_ESC) begin
          b = ESC_BYTE;
        end else begin
          close_frame(ST_BAD_ESC);
          return;
        end
      end else if (b == ESC_BYTE) begin
        esc_pending = 1'b1;
        return;
      end
      case (rx_state)
        RX_HEADER: begin
          hdr[count] = b;
          crc = crc_byte(crc, b);
          count++;
          if (count >= HDR_BYTES) begin
            count = '0;
            rx_state = (hdr[5] == 0) ? RX_CHECKSUM : RX_PAYLOAD;
          end
        end
        RX_PAYLOAD: begin
          idx = count;
          emit = idx < copy_max;
          crc = crc_byte(crc, b);
          count++;
          if (count >= hdr[5]) begin
            count = '0;
            rx_state = RX_CHECKSUM;
          end
          if (emit) begin
            r = header_record();
            r.data_byte = b;
            r.byte_index = idx;
            expected_q.push_back(r);
          end
        end
        default: begin
          if (count == 0) begin
            crc_lo = b;
            count = 8'd1;
          end else begin
            got = {b, crc_lo};
            if (got != crc) close_frame(ST_BAD_CRC);
            else if (require_req && hdr[2] != 0) close_frame(ST_BAD_MODE);
            else close_frame(ST_OK);
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %02h expected %02h", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, kind %0d status %0d",
                         got.kind, got.status));
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 8'(got.kind), 8'(want.kind));
      compare_field("data_byte", got.data_byte, want.data_byte);
      compare_field("byte_index", got.byte_index, want.byte_index);
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("src_addr", got.src_addr, want.src_addr);
      compare_field("trg_addr", got.trg_addr, want.trg_addr);
      compare_field("frame_mode", got.frame_mode, want.frame_mode);
      compare_field("msg_id", got.msg_id, want.msg_id);
      compare_field("ans_id", got.ans_id, want.ans_id);
      compare_field("payload_length", got.payload_length, want.payload_length);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  frame_scoreboard sb;
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_long    = 1'b0;
  int items_sent   = 0;
  int cur_timeout  = 100;
  int stall_cycles = 0;

  stuffed_frame_receiver_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_ch),
    .out_m   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.mode, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.kind           = out_ch.kind;
        got.data_byte      = out_ch.data_byte;
        got.byte_index     = out_ch.byte_index;
        got.status         = out_ch.status;
        got.src_addr       = out_ch.src_addr;
        got.trg_addr       = out_ch.trg_addr;
        got.frame_mode     = out_ch.frame_mode;
        got.msg_id         = out_ch.msg_id;
        got.ans_id         = out_ch.ans_id;
        got.payload_length = out_ch.payload_length;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("stuffed_frame_receiver_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic logic [7:0] pick_octet();
    case ($urandom_range(0, 9))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return ESC_FLAG;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(logic is_tick, logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= is_tick;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_stuffed(logic [7:0] b);
    if (b == FLAG_BYTE && $urandom_range(0, 7) == 0) begin
      send_item(1'b0, b);
    end else if (b == FLAG_BYTE) begin
      send_item(1'b0, ESC_BYTE);
      send_item(1'b0, ESC_FLAG);
    end else if (b == ESC_BYTE) begin
      send_item(1'b0, ESC_BYTE);
      send_item(1'b0, ESC_ESC);
    end else begin
      send_item(1'b0, b);
    end
  endtask

  task automatic send_frame(octet_q_t content, frame_fault_t fault, int cut);
    logic [15:0] sum;
    logic [7:0]  bad;
    octet_q_t    body;
    int          gap;
    sum = '0;
    foreach (content[i]) sum = frame_scoreboard::crc_byte(sum, content[i]);
    if (fault == FAULT_CRC) sum[7:0] = sum[7:0] ^ 8'($urandom_range(1, 255));
    body = content;
    body.push_back(sum[7:0]);
    body.push_back(sum[15:8]);
    send_item(1'b0, FLAG_BYTE);
    foreach (body[i]) begin
      if (i == cut && fault == FAULT_ESCAPE) begin
        do bad = 8'($urandom); while (bad == ESC_FLAG || bad == ESC_ESC);
        send_item(1'b0, ESC_BYTE);
        send_item(1'b0, bad);
        return;
      end
      if (i == cut && fault == FAULT_TIMEOUT) begin
        repeat (cur_timeout) send_item(1'b1, 8'($urandom));
        return;
      end
      if ($urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 3);
        if (cur_timeout == 0 || gap < cur_timeout) repeat (gap) send_item(1'b1, 8'($urandom));
      end
      send_stuffed(body[i]);
    end
  endtask

  task automatic send_random_frame(frame_fault_t fault, int len);
    octet_q_t content;
    repeat (5) content.push_back(pick_octet());
    case ($urandom_range(0, 7))
      0: content[2] = 8'h01;
      1: content[2] = pick_octet();
      default: content[2] = 8'h00;
    endcase
    content.push_back(8'(len));
    repeat (len) content.push_back(pick_octet());
    send_frame(content, fault, $urandom_range(0, len + 7));
  endtask

  task automatic send_random_unit();
    int           pick;
    int           len;
    logic [7:0]   noise;
    frame_fault_t fault;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) begin
        noise = 8'($urandom);
        if (noise == FLAG_BYTE) noise = 8'h00;
        send_item(1'b0, noise);
      end
    end else if (pick < 12) begin
      repeat ($urandom_range(1, 4)) send_item(1'b1, 8'($urandom));
    end else begin
      fault = FAULT_NONE;
      if (pick < 20) fault = FAULT_ESCAPE;
      else if (pick < 28) fault = FAULT_CRC;
      else if (pick < 33 && cur_timeout != 0 && cur_timeout <= 40) fault = FAULT_TIMEOUT;
      send_random_frame(fault, len);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(bit req, logic [7:0] lim, logic [15:0] limit_ticks);
    drain();
    apb_write(REG_REQUIRE, {31'd0, req});
    apb_write(REG_LIMIT, {24'd0, lim});
    apb_write(REG_TIMEOUT, {16'd0, limit_ticks});
    cur_timeout = limit_ticks;
  endtask

  initial begin
    octet_q_t    pkt;
    bit          req;
    logic [7:0]  lim;
    logic [15:0] limit_ticks;
    int          start;
    sb = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(1'b1, 8'hA5);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    pkt = '{8'h7E, 8'h7D, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h7D, 8'h7E};
    send_frame(pkt, FAULT_NONE, 0);
    pkt = '{8'h01, 8'h02, 8'h01, 8'h80, 8'h00, 8'h00};
    send_frame(pkt, FAULT_NONE, 0);
    pkt = '{8'h33, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(pkt, FAULT_ESCAPE, 2);

    for (int p = 0; items_sent < ITEMS || p < 6; p++) begin
      case (p)
        0: begin req = 1'b1; lim = 8'd255; limit_ticks = 16'd100;   end
        1: begin req = 1'b0; lim = 8'd0;   limit_ticks = 16'd0;     end
        2: begin req = 1'b1; lim = 8'd1;   limit_ticks = 16'd1;     end
        3: begin req = 1'b0; lim = 8'd3;   limit_ticks = 16'd20;    end
        default: begin
          req = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 5))
            0: lim = 8'd0;
            1: lim = 8'd1;
            2: lim = 8'd2;
            3: lim = 8'd5;
            4: lim = 8'd255;
            default: lim = 8'($urandom);
          endcase
          case ($urandom_range(0, 5))
            0: limit_ticks = 16'd0;
            1: limit_ticks = 16'd1;
            2: limit_ticks = 16'd2;
            3: limit_ticks = 16'd7;
            4: limit_ticks = 16'd30;
            default: limit_ticks = 16'($urandom_range(3, 300));
          endcase
        end
      endcase
      set_config(req, lim, limit_ticks);
      if (items_sent >= ITEMS - 150) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      if (p == 0) begin
        hold_long = 1'b1;
        send_random_frame(FAULT_NONE, 255);
      end
      if (p == 3) send_random_frame(FAULT_TIMEOUT, 4);
      start = items_sent;
      while (items_sent - start < 110) send_random_unit();
    end

    drain();
    if (sb.errors == 0) begin
      $display("stuffed_frame_receiver_top regression: pass");
    end else begin
      $display("stuffed_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
